// ----- rtl/assert_macros.svh -----
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication check, sampled on the rising clock, off while reset is high.
`define SHC_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition that must never be seen while out of reset.
`define SHC_ASSERT_NEVER(label, clk, rst, cond, msg) \
   `SHC_ASSERT(label, clk, rst, !(cond), msg)

`endif

// ----- rtl/shc_pkg.sv -----
// Types and constants shared by the shape hit counter modules.
`default_nettype none
package shc_pkg;

   typedef logic [1:0] op_type;
   localparam op_type OP_LOAD_RECT   = 2'd0;
   localparam op_type OP_LOAD_CIRCLE = 2'd1;
   localparam op_type OP_SHOT        = 2'd2;

   localparam logic signed [15:0] FIELD_MIN = -16'sd1000;
   localparam logic signed [15:0] FIELD_MAX = 16'sd1000;
   localparam logic [7:0]         HIT_MAX   = 8'hFF;

   // Shot moving down the cell row; x and y fit 11 bits once inside the field.
   typedef struct packed {
      logic              valid;
      logic              live;
      logic signed [10:0] x;
      logic signed [10:0] y;
      logic [7:0]        hits;
   } tok_type;

   typedef struct packed {
      logic signed [15:0] llx;
      logic signed [15:0] lly;
      logic signed [15:0] urx;
      logic signed [15:0] ury;
   } rect_type;

   typedef struct packed {
      logic signed [15:0] cx;
      logic signed [15:0] cy;
      logic [29:0]        rsq;
   } circ_type;

   function automatic logic [7:0] sat_inc(input logic [7:0] v);
      sat_inc = (v == HIT_MAX) ? v : v + 8'd1;
   endfunction

endpackage
`default_nettype wire

// ----- rtl/shape_hit_counter.sv -----
// Top level of the shape hit counter: load stage, cell row and result register.
`default_nettype none
// Stores up to MAX_RECTS rectangles and MAX_CIRCLES circles, one per load item
// (req_tuser 0 rectangle, 1 circle); a load into a full table is dropped and
// code 3 is ignored. A shot item (req_tuser 2) travels down a row of cells,
// one cell per stored shape: a rectangle cell compares it to its bounds, a
// circle cell squares the offsets, then sums and compares. The shot's result
// is registered into rsp_tdata at the end of the row, and the input reopens
// in that same cycle as the result appears. The row stalls only while the
// finished shot waits on an unread result. A load closes the input while the
// shape is written into its cell, so a new load is taken only once the last
// is written, and no load is taken while a shot is in the row. Hit counts are
// borders-inclusive, saturate at 255, and are zero for a shot with x or y
// outside -1000..1000.
module shape_hit_counter #(
   parameter int MAX_RECTS   = 64,
   parameter int MAX_CIRCLES = 64
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // [15:0] ax, [31:16] ay, [47:32] bx, [63:48] by, [78:64] radius, [79] zero
   input  wire logic [79:0] req_tdata,
   // [1:0] op
   input  wire logic [1:0]  req_tuser,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // [7:0] hit_count
   output logic [7:0]       rsp_tdata
);
   import shc_pkg::*;

   localparam int RCNT_W = $clog2(MAX_RECTS + 1);
   localparam int CCNT_W = $clog2(MAX_CIRCLES + 1);

   logic req_acc_w, shot_acc_w, advance_w;
   logic busy_ff, busy_in;
   logic signed [15:0] ax_w, ay_w;

   logic      load_vld_ff;
   op_type    load_op_ff;
   rect_type  load_rect_ff;
   logic [14:0] load_rad_ff;
   circ_type  wr_circ_w;
   logic      rect_wr_w, circ_wr_w;

   logic [RCNT_W-1:0] rect_count_ff;
   logic [CCNT_W-1:0] circ_count_ff;

   tok_type entry_w, tail_w;
   tok_type rect_tok [MAX_RECTS + 1];
   tok_type circ_tok [MAX_CIRCLES + 1];

   logic rsp_valid_ff;
   logic [7:0] rsp_data_ff;

   assign ax_w = $signed(req_tdata[15:0]);
   assign ay_w = $signed(req_tdata[31:16]);

   // a pending load write must land before a shot can meet the first cell
   assign req_tready = !busy_ff && !load_vld_ff;
   assign req_acc_w  = req_tvalid && req_tready;
   assign shot_acc_w = req_acc_w && (req_tuser == OP_SHOT);

   // the row holds only while the finished shot waits on a full result register
   assign tail_w    = circ_tok[MAX_CIRCLES];
   assign advance_w = !(tail_w.valid && rsp_valid_ff && !rsp_tready);

   always_comb begin
      busy_in = busy_ff;
      if (shot_acc_w) begin
         busy_in = 1'b1;
      end else if (tail_w.valid && advance_w) begin
         busy_in = 1'b0;
      end
   end

   always_comb begin
      entry_w       = '0;
      entry_w.valid = shot_acc_w;
      entry_w.live  = (ax_w >= FIELD_MIN) && (ax_w <= FIELD_MAX) &&
                      (ay_w >= FIELD_MIN) && (ay_w <= FIELD_MAX);
      entry_w.x     = ax_w[10:0];
      entry_w.y     = ay_w[10:0];
   end

   // load stage; the squared radius is formed on the way into the cell
   always_ff @(posedge clock) begin
      if (reset) begin
         load_vld_ff <= 1'b0;
      end else begin
         load_vld_ff <= req_acc_w && ((req_tuser == OP_LOAD_RECT) ||
                                      (req_tuser == OP_LOAD_CIRCLE));
      end
   end

   always_ff @(posedge clock) begin
      load_op_ff       <= req_tuser;
      load_rect_ff.llx <= $signed(req_tdata[15:0]);
      load_rect_ff.lly <= $signed(req_tdata[31:16]);
      load_rect_ff.urx <= $signed(req_tdata[47:32]);
      load_rect_ff.ury <= $signed(req_tdata[63:48]);
      load_rad_ff      <= req_tdata[78:64];
   end

   always_comb begin
      wr_circ_w.cx  = load_rect_ff.llx;
      wr_circ_w.cy  = load_rect_ff.lly;
      wr_circ_w.rsq = {15'd0, load_rad_ff} * {15'd0, load_rad_ff};
   end

   assign rect_wr_w = load_vld_ff && (load_op_ff == OP_LOAD_RECT) &&
                      (rect_count_ff < RCNT_W'(MAX_RECTS));
   assign circ_wr_w = load_vld_ff && (load_op_ff == OP_LOAD_CIRCLE) &&
                      (circ_count_ff < CCNT_W'(MAX_CIRCLES));

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff       <= 1'b0;
         rect_count_ff <= '0;
         circ_count_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         if (rect_wr_w) begin
            rect_count_ff <= rect_count_ff + RCNT_W'(1);
         end
         if (circ_wr_w) begin
            circ_count_ff <= circ_count_ff + CCNT_W'(1);
         end
      end
   end

   assign rect_tok[0] = entry_w;
   assign circ_tok[0] = rect_tok[MAX_RECTS];

   for (genvar i = 0; i < MAX_RECTS; i++) begin : g_rect
      shc_rect_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .advance (advance_w),
         .active  (RCNT_W'(i) < rect_count_ff),
         .wr_en   (rect_wr_w && (rect_count_ff == RCNT_W'(i))),
         .wr_rect (load_rect_ff),
         .tok_in  (rect_tok[i]),
         .tok_out (rect_tok[i+1])
      );
   end

   for (genvar i = 0; i < MAX_CIRCLES; i++) begin : g_circ
      shc_circ_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .advance (advance_w),
         .active  (CCNT_W'(i) < circ_count_ff),
         .wr_en   (circ_wr_w && (circ_count_ff == CCNT_W'(i))),
         .wr_circ (wr_circ_w),
         .tok_in  (circ_tok[i]),
         .tok_out (circ_tok[i+1])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (tail_w.valid && advance_w) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (tail_w.valid && advance_w) begin
         rsp_data_ff <= tail_w.hits;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
`default_nettype wire

// ----- rtl/shc_rect_cell.sv -----
// One rectangle cell: holds a rectangle and tests the passing shot against it.
`default_nettype none
module shc_rect_cell (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             advance,
   input  wire logic             active,
   input  wire logic             wr_en,
   input  wire shc_pkg::rect_type wr_rect,
   input  wire shc_pkg::tok_type  tok_in,
   output shc_pkg::tok_type       tok_out
);
   import shc_pkg::*;

   rect_type rect_ff;
   tok_type  tok_ff, tok_in_w;
   logic signed [15:0] x_w, y_w;
   logic hit_w;

   assign x_w = $signed({{5{tok_in.x[10]}}, tok_in.x});
   assign y_w = $signed({{5{tok_in.y[10]}}, tok_in.y});

   always_comb begin
      hit_w = active && tok_in.live &&
              (x_w >= rect_ff.llx) && (x_w <= rect_ff.urx) &&
              (y_w >= rect_ff.lly) && (y_w <= rect_ff.ury);
      tok_in_w = tok_in;
      if (hit_w) begin
         tok_in_w.hits = sat_inc(tok_in.hits);
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         rect_ff <= wr_rect;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff <= '0;
      end else if (advance) begin
         tok_ff <= tok_in_w;
      end
   end

   assign tok_out = tok_ff;

endmodule
`default_nettype wire

// ----- rtl/shc_circ_cell.sv -----
// One circle cell: holds a circle, squares the offsets, then compares to r^2.
`default_nettype none
module shc_circ_cell (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             advance,
   input  wire logic             active,
   input  wire logic             wr_en,
   input  wire shc_pkg::circ_type wr_circ,
   input  wire shc_pkg::tok_type  tok_in,
   output shc_pkg::tok_type       tok_out
);
   import shc_pkg::*;

   circ_type circ_ff;
   tok_type  mid_ff, tok_ff, mid_w;
   logic signed [16:0] dx_w, dy_w;
   logic signed [33:0] px_w, py_w;
   logic [30:0] sqx_ff, sqy_ff, sqx_in, sqy_in;
   logic [31:0] sum_w;
   logic hit_w;

   // stage 1: offsets and their squares (|dx| <= 33791, square < 2^31)
   always_comb begin
      dx_w   = $signed({{6{tok_in.x[10]}}, tok_in.x}) - $signed({circ_ff.cx[15], circ_ff.cx});
      dy_w   = $signed({{6{tok_in.y[10]}}, tok_in.y}) - $signed({circ_ff.cy[15], circ_ff.cy});
      px_w   = 34'(dx_w) * 34'(dx_w);
      py_w   = 34'(dy_w) * 34'(dy_w);
      sqx_in = px_w[30:0];
      sqy_in = py_w[30:0];
   end

   // stage 2: sum and compare against the stored squared radius
   always_comb begin
      sum_w = {1'b0, sqx_ff} + {1'b0, sqy_ff};
      hit_w = active && mid_ff.live && (sum_w <= {2'b00, circ_ff.rsq});
      mid_w = mid_ff;
      if (hit_w) begin
         mid_w.hits = sat_inc(mid_ff.hits);
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         circ_ff <= wr_circ;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         sqx_ff <= sqx_in;
         sqy_ff <= sqy_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mid_ff <= '0;
         tok_ff <= '0;
      end else if (advance) begin
         mid_ff <= tok_in;
         tok_ff <= mid_w;
      end
   end

   assign tok_out = tok_ff;

endmodule
`default_nettype wire

// ----- rtl/shc_checker.sv -----
// Port-level checks for the shape hit counter, bound to the top level.
`default_nettype none
`include "assert_macros.svh"
module shc_checker #(
   parameter int MAX_RECTS   = 64,
   parameter int MAX_CIRCLES = 64
) (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic [79:0] req_tdata,
   input wire logic [1:0]  req_tuser,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [7:0]  rsp_tdata
);
   import shc_pkg::*;

   localparam int HIT_LIMIT = (MAX_RECTS + MAX_CIRCLES > 255) ? 255
                                                              : MAX_RECTS + MAX_CIRCLES;

   logic shot_acc_w;
   assign shot_acc_w = req_tvalid && req_tready && (req_tuser == OP_SHOT) &&
                       (req_tdata[79] == 1'b0 || req_tdata[79] == 1'b1);

   `SHC_ASSERT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid, "result dropped while stalled")
   `SHC_ASSERT(a_rsp_stable, clock, reset, rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata), "stalled result changed")
   `SHC_ASSERT(a_shot_busy, clock, reset, shot_acc_w |=> !req_tready, "item taken while a shot is in flight")
   `SHC_ASSERT(a_rsp_frees, clock, reset, $rose(rsp_tvalid) |-> req_tready, "input not reopened with result")
   `SHC_ASSERT_NEVER(a_hit_bound, clock, reset, rsp_tvalid && (rsp_tdata > 8'(HIT_LIMIT)), "hit count above stored shapes")

endmodule

bind shape_hit_counter shc_checker #(
   .MAX_RECTS   (MAX_RECTS),
   .MAX_CIRCLES (MAX_CIRCLES)
) u_shc_checker (.*);
`default_nettype wire
